[hw/rtl/rrc_pkg.sv]
// shared types, constants and helpers for the register range coalescer
// no dependencies; compiled first

package rrc_pkg;

  // default table depth
  localparam int unsigned MAX_RANGES_DEF = 16;

  // configuration port geometry and register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPAN   = 1'd1;
  localparam logic [CFG_DATA_W-1:0] MAX_SPAN_RST  = 10'd200;

  // item kinds
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_JOIN,
    S_REM,
    S_INS,
    S_PUT,
    S_DONE
  } state_e;

  // input item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] register_number;
    logic [3:0]  entry_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [15:0] range_start;
    logic [7:0]  range_length;
    logic        entry_valid;
    logic [4:0]  range_total;
    logic        overflow;
  } out_item_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [15:0] start;
    logic [7:0]  length;
  } entry_t;

  // length saturated to the 8-bit field
  function automatic logic [7:0] sat_len(input logic [16:0] n);
    logic [7:0] r;
    r = (n > 17'd255) ? 8'hFF : n[7:0];
    return r;
  endfunction

endpackage

[hw/rtl/rrc_stream_if.sv]
// valid/ready channel carrying one payload of a given type
// no dependencies; the payload type comes in as a parameter

interface rrc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/register_range_coalescer.sv]
// register range coalescer: sorted range table with add, read and clear
// depends on rrc_pkg and rrc_stream_if

// The table of ranges lives in one synchronous memory of MAX_RANGES entries
// (16-bit start, 8-bit length) with a single read port and a single write
// port; one sequencer walks it one entry per cycle. A read or a clear needs
// no scan of the table. An add scans the entries in order, then moves the
// entries after the insertion point when it inserts a new range, or the
// entries after the joined one when it joins two ranges. A new item is
// taken once the previous one has placed its result in the output register,
// so a result that waits for its transfer does not hold back the next item.
// There is no clearing pass after reset; entries past the count are never
// read.
module register_range_coalescer #(
  parameter int unsigned MAX_RANGES = rrc_pkg::MAX_RANGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rrc_stream_if.sink                    in_ch,
  rrc_stream_if.source                  out_ch
);
  import rrc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_RANGES);
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);

  // configuration registers
  logic                  merge_q;
  logic [CFG_DATA_W-1:0] span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_q <= 1'b0;
      span_q  <= MAX_SPAN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MERGE_MODE: merge_q <= cfg_data_i[0];
        CFG_MAX_SPAN:   span_q  <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // range memory, one read and one write port
  entry_t          entry_mem_q [MAX_RANGES];
  entry_t          rd_data_q;
  logic            mem_re;
  logic [AW-1:0]   mem_ra;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  entry_t          mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= entry_mem_q[mem_ra];
    end
  end

  // sequencer and item registers
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] k_q, k_d;
  logic [15:0]   reg_q, reg_d;
  logic [15:0]   s_q, s_d;
  logic [16:0]   ne_q, ne_d;
  logic          hit_q, hit_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    k_q   <= k_d;
    reg_q <= reg_d;
    s_q   <= s_d;
    ne_q  <= ne_d;
    hit_q <= hit_d;
    ovf_q <= ovf_d;
    out_q <= out_d;
  end

  assign in_ch.ready    = (state_q == S_IDLE);
  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  // arithmetic on the entry under scan
  logic [16:0] reg_x, s_x, e_x, front_span, back_ne, back_span;
  logic        front_ok, back_ok;
  logic [16:0] nx_x, ne_join;
  logic [CW-1:0] i_inc, k_inc, k_dec;
  logic [31:0] idx_ext, cnt_ext;

  always_comb begin
    reg_x      = {1'b0, reg_q};
    s_x        = {1'b0, rd_data_q.start};
    e_x        = s_x + {9'd0, rd_data_q.length};
    front_span = e_x - reg_x;
    front_ok   = (merge_q || ((reg_x + 17'd1) >= s_x)) &&
                 ({front_span, 1'b0} < 18'(span_q));
    back_ne    = reg_x + 17'd1;
    back_span  = back_ne - s_x;
    back_ok    = (merge_q || (reg_x == e_x)) &&
                 ({back_span, 1'b0} < 18'(span_q));
    nx_x       = s_x + {9'd0, rd_data_q.length};
    ne_join    = (nx_x > ne_q) ? nx_x : ne_q;
    i_inc      = i_q + CW'(1);
    k_inc      = k_q + CW'(1);
    k_dec      = k_q - CW'(1);
    idx_ext    = 32'(in_ch.payload.entry_index);
    cnt_ext    = 32'(count_q);
  end

  // next state, memory accesses and result
  logic          ins_req;
  logic [CW-1:0] ins_pos;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    k_d         = k_q;
    reg_d       = reg_q;
    s_d         = s_q;
    ne_d        = ne_q;
    hit_d       = hit_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_ra      = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = rd_data_q;
    ins_req     = 1'b0;
    ins_pos     = i_q;

    case (state_q)
      // take an item and start its work
      S_IDLE: begin
        if (in_ch.valid) begin
          reg_d = in_ch.payload.register_number;
          hit_d = 1'b0;
          ovf_d = 1'b0;
          i_d   = '0;
          case (in_ch.payload.kind)
            KIND_ADD: begin
              if (count_q == '0) begin
                state_d = S_PUT;
              end else begin
                mem_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
            KIND_READ: begin
              if (idx_ext < cnt_ext) begin
                hit_d  = 1'b1;
                mem_re = 1'b1;
                mem_ra = AW'(idx_ext);
              end
              state_d = S_DONE;
            end
            KIND_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // entry i is in the read register
      S_SCAN: begin
        if (reg_q < rd_data_q.start) begin
          if (front_ok) begin
            mem_we  = 1'b1;
            mem_wa  = AW'(i_q);
            mem_wd  = '{start: reg_q, length: sat_len(front_span)};
            state_d = S_DONE;
          end else begin
            ins_req = 1'b1;
            ins_pos = i_q;
          end
        end else if (reg_x >= e_x) begin
          if (back_ok) begin
            s_d  = rd_data_q.start;
            ne_d = back_ne;
            if (!merge_q && (i_inc < count_q)) begin
              mem_re  = 1'b1;
              mem_ra  = AW'(i_inc);
              state_d = S_JOIN;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = AW'(i_q);
              mem_wd  = '{start: rd_data_q.start, length: sat_len(back_span)};
              state_d = S_DONE;
            end
          end else if (i_inc < count_q) begin
            i_d    = i_inc;
            mem_re = 1'b1;
            mem_ra = AW'(i_inc);
          end else begin
            ins_req = 1'b1;
            ins_pos = count_q;
          end
        end else begin
          state_d = S_DONE;
        end

        // new one-register entry at ins_pos
        if (ins_req) begin
          i_d = ins_pos;
          if (count_q == CW'(MAX_RANGES)) begin
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else if (count_q > ins_pos) begin
            k_d     = count_q;
            mem_re  = 1'b1;
            mem_ra  = AW'(count_q - CW'(1));
            state_d = S_INS;
          end else begin
            state_d = S_PUT;
          end
        end
      end

      // next entry is in the read register: join when the grown end reaches it
      S_JOIN: begin
        mem_we = 1'b1;
        mem_wa = AW'(i_q);
        if (ne_q >= s_x) begin
          mem_wd = '{start: s_q, length: sat_len(ne_join - {1'b0, s_q})};
          k_d    = i_inc;
          if ((i_inc + CW'(1)) < count_q) begin
            mem_re  = 1'b1;
            mem_ra  = AW'(i_inc + CW'(1));
            state_d = S_REM;
          end else begin
            count_d = count_q - CW'(1);
            state_d = S_DONE;
          end
        end else begin
          mem_wd  = '{start: s_q, length: sat_len(ne_q - {1'b0, s_q})};
          state_d = S_DONE;
        end
      end

      // close the gap: entry k+1 moves down to k
      S_REM: begin
        mem_we = 1'b1;
        mem_wa = AW'(k_q);
        mem_wd = rd_data_q;
        k_d    = k_inc;
        if ((k_inc + CW'(1)) < count_q) begin
          mem_re = 1'b1;
          mem_ra = AW'(k_inc + CW'(1));
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      // open a gap: entry k-1 moves up to k
      S_INS: begin
        mem_we = 1'b1;
        mem_wa = AW'(k_q);
        mem_wd = rd_data_q;
        k_d    = k_dec;
        if (k_dec > i_q) begin
          mem_re = 1'b1;
          mem_ra = AW'(k_dec - CW'(1));
        end else begin
          state_d = S_PUT;
        end
      end

      // write the new entry
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(i_q);
        mem_wd  = '{start: reg_q, length: 8'd1};
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end

      // load the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ch.ready) begin
          out_valid_d        = 1'b1;
          out_d.range_start  = hit_q ? rd_data_q.start : 16'd0;
          out_d.range_length = hit_q ? rd_data_q.length : 8'd0;
          out_d.entry_valid  = hit_q;
          out_d.range_total  = 5'(count_q);
          out_d.overflow     = ovf_q;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[dv/register_range_coalescer_test.sv]
`timescale 1ns / 1ps
// self-checking bench for register_range_coalescer: directed and random add/read/clear traffic
// with a cycle-free range table model; depends on rrc_pkg and rrc_stream_if

module register_range_coalescer_test;
  import rrc_pkg::*;

  localparam int unsigned DEPTH       = MAX_RANGES_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SQUEEZE_LEN = 400;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rrc_stream_if #(.payload_t(in_item_t))  in_if ();
  rrc_stream_if #(.payload_t(out_item_t)) out_if ();

  register_range_coalescer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_if),
    .out_ch     (out_if)
  );

  always #10 clk_i = ~clk_i;

  // range table model state
  logic [15:0]     tbl_start [DEPTH];
  logic [7:0]      tbl_len   [DEPTH];
  int unsigned     tbl_count;
  logic            cfg_merge;
  logic [9:0]      cfg_span;

  in_item_t        pending_ops[$];
  out_item_t       predicted_replies[$];

  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  bit              squeeze_request;
  int unsigned     squeeze_left;
  int unsigned     mismatch_count;
  int unsigned     ops_sent;
  int unsigned     replies_seen;
  int unsigned     overflow_hits;
  int unsigned     live_reads;
  int unsigned     settings_used;
  int unsigned     quiet_cycles;

  function automatic logic [7:0] clip_len(int unsigned n);
    return (n > 255) ? 8'hFF : 8'(n);
  endfunction

  // open a one-register range at pos; returns 1 when the table is full
  function automatic bit place_entry(int unsigned pos, logic [15:0] r);
    if (tbl_count >= DEPTH) return 1'b1;
    for (int unsigned k = tbl_count; k > pos; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k]   = tbl_len[k-1];
    end
    tbl_start[pos] = r;
    tbl_len[pos]   = 8'd1;
    tbl_count++;
    return 1'b0;
  endfunction

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned k = pos; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k]   = tbl_len[k+1];
    end
    tbl_count--;
  endfunction

  // scan the sorted table and grow, join or open a range; returns overflow
  function automatic bit coalesce_register(logic [15:0] r);
    int unsigned s, e, ne, nx, rv;
    rv = r;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      s = tbl_start[i];
      e = s + tbl_len[i];
      if (rv < s) begin
        // grow at the front, otherwise open a range ahead of this one
        if ((cfg_merge || rv + 1 >= s) && 2 * (e - rv) < cfg_span) begin
          tbl_start[i] = r;
          tbl_len[i]   = clip_len(e - rv);
          return 1'b0;
        end
        return place_entry(i, r);
      end
      if (rv >= e) begin
        // grow at the back, joining the next range when it is reached
        if ((cfg_merge || rv == e) && 2 * (rv + 1 - s) < cfg_span) begin
          ne = rv + 1;
          if (!cfg_merge && i + 1 < tbl_count && ne >= tbl_start[i+1]) begin
            nx = tbl_start[i+1] + tbl_len[i+1];
            if (nx > ne) ne = nx;
            drop_entry(i + 1);
          end
          tbl_len[i] = clip_len(ne - s);
          return 1'b0;
        end
        continue;
      end
      // already covered
      return 1'b0;
    end
    return place_entry(tbl_count, r);
  endfunction

  function automatic out_item_t predict_reply(in_item_t op);
    out_item_t rep;
    rep = '0;
    case (op.kind)
      KIND_ADD: begin
        rep.overflow = coalesce_register(op.register_number);
      end
      KIND_READ: begin
        if (op.entry_index < tbl_count) begin
          rep.range_start  = tbl_start[op.entry_index];
          rep.range_length = tbl_len[op.entry_index];
          rep.entry_valid  = 1'b1;
        end
      end
      KIND_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    rep.range_total = 5'(tbl_count);
    return rep;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // input driver: offer queued ops, predict on each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.payload <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predicted_replies.push_back(predict_reply(in_if.payload));
        if (predicted_replies[$].overflow) overflow_hits++;
        if (predicted_replies[$].entry_valid) live_reads++;
        ops_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.payload <= pending_ops.pop_front();
          in_if.valid   <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: check each transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      squeeze_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          flag_mismatch("reply with nothing predicted", 32'(out_if.payload), '0);
        end else begin
          out_item_t want;
          want = predicted_replies.pop_front();
          if (out_if.payload.range_start !== want.range_start)
            flag_mismatch("range_start", 32'(out_if.payload.range_start),
                          32'(want.range_start));
          if (out_if.payload.range_length !== want.range_length)
            flag_mismatch("range_length", 32'(out_if.payload.range_length),
                          32'(want.range_length));
          if (out_if.payload.entry_valid !== want.entry_valid)
            flag_mismatch("entry_valid", 32'(out_if.payload.entry_valid),
                          32'(want.entry_valid));
          if (out_if.payload.range_total !== want.range_total)
            flag_mismatch("range_total", 32'(out_if.payload.range_total),
                          32'(want.range_total));
          if (out_if.payload.overflow !== want.overflow)
            flag_mismatch("overflow", 32'(out_if.payload.overflow),
                          32'(want.overflow));
        end
      end
      // long hold-off so the block backs up into its input
      if (squeeze_request) begin
        squeeze_left    = SQUEEZE_LEN;
        squeeze_request = 1'b0;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d replies outstanding",
                 $time, quiet_cycles, predicted_replies.size());
        $display("register_range_coalescer regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MERGE_MODE) cfg_merge = data[0];
    else cfg_span = data;
  endtask

  task automatic set_mode(bit merge, logic [9:0] span);
    write_reg(CFG_MERGE_MODE, CFG_DATA_W'(merge));
    write_reg(CFG_MAX_SPAN, span);
    settings_used++;
    @(negedge clk_i);
  endtask

  task automatic push_op(logic [1:0] kind, logic [15:0] r, logic [3:0] idx);
    in_item_t op;
    op.kind            = kind;
    op.register_number = r;
    op.entry_index     = idx;
    pending_ops.push_back(op);
  endtask

  // idle once nothing is queued, offered or awaiting its reply
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_if.valid || predicted_replies.size() != 0);
  endtask

  // adds cluster in a window so ranges grow and join; the rest is mixed traffic
  task automatic run_phase(bit merge, logic [9:0] span, int unsigned sidle,
                           int unsigned rstall, int unsigned n, int unsigned base,
                           int unsigned width, bit squeeze);
    in_item_t    op;
    int unsigned pick;
    wait_drained();
    set_mode(merge, span);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    for (int unsigned k = 0; k < n; k++) begin
      pick               = $urandom_range(99);
      op.register_number = 16'($urandom);
      op.entry_index     = 4'($urandom_range(15));
      if (pick < 70) begin
        op.kind            = KIND_ADD;
        op.register_number = 16'(base + $urandom_range(width - 1));
      end else if (pick < 78) begin
        op.kind = KIND_ADD;
      end else if (pick < 92) begin
        op.kind = KIND_READ;
      end else if (pick < 96) begin
        op.kind = KIND_CLEAR;
      end else begin
        op.kind = KIND_UNUSED;
      end
      pending_ops.push_back(op);
    end
    if (squeeze) squeeze_request = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.payload   = '0;
    out_if.ready    = 1'b0;
    tbl_count       = 0;
    cfg_merge       = 1'b0;
    cfg_span        = MAX_SPAN_RST;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    squeeze_request = 1'b0;
    mismatch_count  = 0;
    ops_sent        = 0;
    replies_seen    = 0;
    overflow_hits   = 0;
    live_reads      = 0;
    settings_used   = 0;
    quiet_cycles    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: grow both ways, join, insert, append, covered, reads, clear
    set_mode(1'b0, MAX_SPAN_RST);
    push_op(KIND_READ,   16'd0,     4'd0);
    push_op(KIND_ADD,    16'd0,     4'd15);
    push_op(KIND_ADD,    16'hFFFF,  4'd0);
    push_op(KIND_ADD,    16'd1,     4'd0);
    push_op(KIND_ADD,    16'd3,     4'd0);
    push_op(KIND_ADD,    16'd2,     4'd0);
    push_op(KIND_ADD,    16'hFFFE,  4'd0);
    push_op(KIND_ADD,    16'd10,    4'd0);
    push_op(KIND_ADD,    16'd9,     4'd0);
    push_op(KIND_ADD,    16'd2,     4'd0);
    push_op(KIND_READ,   16'hFFFF,  4'd0);
    push_op(KIND_READ,   16'd0,     4'd1);
    push_op(KIND_READ,   16'd0,     4'd2);
    push_op(KIND_READ,   16'd0,     4'd15);
    push_op(KIND_UNUSED, 16'hFFFF,  4'd15);
    push_op(KIND_CLEAR,  16'd0,     4'd0);
    push_op(KIND_READ,   16'd0,     4'd0);
    push_op(KIND_ADD,    16'd5,     4'd0);

    // random phases over settings and idle patterns; each boundary drains
    // so the sender also pauses until every reply has come back
    run_phase(1'b0, 10'd200,  0,  0,  80,   100,   64, 1'b0);
    run_phase(1'b1, 10'd512,  67, 0,  70,   1000,  300, 1'b1);
    run_phase(1'b0, 10'd2,    0,  67, 70,   0,     40, 1'b0);
    run_phase(1'b1, 10'd1023, 19, 19, 80,   64935, 600, 1'b0);
    run_phase(1'b0, 10'd0,    0,  0,  40,   30000, 5000, 1'b0);
    run_phase(1'b0, 10'd1023, 67, 0,  80,   20000, 300, 1'b0);
    run_phase(1'b1, 10'd1,    0,  67, 50,   40000, 5000, 1'b0);
    run_phase(1'b0, 10'd200,  19, 19, 60,   65500, 36, 1'b0);

    wait_drained();
    repeat (50) @(negedge clk_i);

    $display("ran %0d ops under %0d register settings, %0d replies checked",
             ops_sent, settings_used, replies_seen);
    $display("table overflows hit: %0d, reads of live ranges: %0d, mismatches: %0d",
             overflow_hits, live_reads, mismatch_count);
    if (mismatch_count == 0) begin
      $display("register_range_coalescer regression: pass");
    end else begin
      $display("register_range_coalescer regression: fail");
    end
    $finish;
  end

endmodule
